### rtl/phmn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phmn_pkg;

  // Field widths of the stream items
  localparam int unsigned PAD_W    = 2;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned VEL_W    = 7;

  // Velocity is peak / 32: drop the five low bits
  localparam int unsigned VEL_SHIFT = 5;

  // Note registers exist for three pads
  localparam int unsigned NUM_NOTE_REGS = 3;

  // Note-on status nibble, channel ORed into the low nibble
  localparam logic [STATUS_W-1:0] STATUS_NOTE_ON = 8'h90;

  // Register file layout (word index = paddr[4:2])
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRIG_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_CHANNEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD0_NOTE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD1_NOTE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD2_NOTE     = 3'd5;

  // Reset values
  localparam logic [LEVEL_W-1:0]  RST_HIT_THRESHOLD = 12'd500;
  localparam logic [WINDOW_W-1:0] RST_RETRIG_WINDOW = 16'd88;
  localparam logic [CHAN_W-1:0]   RST_NOTE_CHANNEL  = 4'd0;
  localparam logic [NOTE_W-1:0]   RST_PAD0_NOTE     = 7'd38;
  localparam logic [NOTE_W-1:0]   RST_PAD1_NOTE     = 7'd42;
  localparam logic [NOTE_W-1:0]   RST_PAD2_NOTE     = 7'd36;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [LEVEL_W-1:0]                   hit_threshold;
    logic [WINDOW_W-1:0]                  retrigger_window_ms;
    logic [CHAN_W-1:0]                    note_channel;
    logic [NUM_NOTE_REGS-1:0][NOTE_W-1:0] pad_note;
  } cfg_t;

  // Result item, packed so the last field lands in the lowest bits
  typedef struct packed {
    logic [VEL_W-1:0]    velocity;
    logic [NOTE_W-1:0]   note_number;
    logic [STATUS_W-1:0] status_byte;
  } note_on_t;

endpackage

`default_nettype wire

### rtl/phmn_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module phmn_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [phmn_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [phmn_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [phmn_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output phmn_pkg::cfg_t                           cfg
);

  logic [phmn_pkg::CFG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  phmn_pkg::cfg_t                 cfg_r;

  assign reg_idx = paddr[phmn_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Write registers on the access phase; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hit_threshold       <= phmn_pkg::RST_HIT_THRESHOLD;
      cfg_r.retrigger_window_ms <= phmn_pkg::RST_RETRIG_WINDOW;
      cfg_r.note_channel        <= phmn_pkg::RST_NOTE_CHANNEL;
      cfg_r.pad_note[0]         <= phmn_pkg::RST_PAD0_NOTE;
      cfg_r.pad_note[1]         <= phmn_pkg::RST_PAD1_NOTE;
      cfg_r.pad_note[2]         <= phmn_pkg::RST_PAD2_NOTE;
    end else if (wr_en) begin
      case (reg_idx)
        phmn_pkg::REG_HIT_THRESHOLD:
          cfg_r.hit_threshold <= pwdata[phmn_pkg::LEVEL_W-1:0];
        phmn_pkg::REG_RETRIG_WINDOW:
          cfg_r.retrigger_window_ms <= pwdata[phmn_pkg::WINDOW_W-1:0];
        phmn_pkg::REG_NOTE_CHANNEL:
          cfg_r.note_channel <= pwdata[phmn_pkg::CHAN_W-1:0];
        phmn_pkg::REG_PAD0_NOTE:
          cfg_r.pad_note[0] <= pwdata[phmn_pkg::NOTE_W-1:0];
        phmn_pkg::REG_PAD1_NOTE:
          cfg_r.pad_note[1] <= pwdata[phmn_pkg::NOTE_W-1:0];
        phmn_pkg::REG_PAD2_NOTE:
          cfg_r.pad_note[2] <= pwdata[phmn_pkg::NOTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    prdata = '0;
    case (reg_idx)
      phmn_pkg::REG_HIT_THRESHOLD:
        prdata = {{(phmn_pkg::CFG_DATA_W-phmn_pkg::LEVEL_W){1'b0}}, cfg_r.hit_threshold};
      phmn_pkg::REG_RETRIG_WINDOW:
        prdata = {{(phmn_pkg::CFG_DATA_W-phmn_pkg::WINDOW_W){1'b0}},
                  cfg_r.retrigger_window_ms};
      phmn_pkg::REG_NOTE_CHANNEL:
        prdata = {{(phmn_pkg::CFG_DATA_W-phmn_pkg::CHAN_W){1'b0}}, cfg_r.note_channel};
      phmn_pkg::REG_PAD0_NOTE:
        prdata = {{(phmn_pkg::CFG_DATA_W-phmn_pkg::NOTE_W){1'b0}}, cfg_r.pad_note[0]};
      phmn_pkg::REG_PAD1_NOTE:
        prdata = {{(phmn_pkg::CFG_DATA_W-phmn_pkg::NOTE_W){1'b0}}, cfg_r.pad_note[1]};
      phmn_pkg::REG_PAD2_NOTE:
        prdata = {{(phmn_pkg::CFG_DATA_W-phmn_pkg::NOTE_W){1'b0}}, cfg_r.pad_note[2]};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/piezo_hit_to_midi_note_on_core.sv
// Path: a sample transaction passes the input register and then the output
// register before its note-on appears on out_tvalid.
// Throughput: one sample per cycle while no note-on is stalled; the per-pad
// compare and state update sit between the input register and the output register.
// Reset (rst_n, synchronous, active low): all pads idle with peak and last hit
// time zero, registers back to their defaults, both stream stages empty.
`timescale 1ns / 1ps
`default_nettype none

module piezo_hit_to_midi_note_on_core #(
  parameter int unsigned NUM_PADS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Sample stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [1:0] pad_index, [13:2] sample_level,
                                       // [45:14] time_ms, [47:46] zero
  // Note-on stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] status_byte, [14:8] note_number,
                                       // [21:15] velocity, [23:22] zero
  // Register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned LEVEL_W = phmn_pkg::LEVEL_W;
  localparam int unsigned TIME_W  = phmn_pkg::TIME_W;
  localparam int unsigned PAD_W   = phmn_pkg::PAD_W;
  localparam int unsigned NOTE_W  = phmn_pkg::NOTE_W;
  localparam int unsigned VEL_W   = phmn_pkg::VEL_W;

  phmn_pkg::cfg_t cfg;

  phmn_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input stage
  logic               s1_valid_r;
  logic [PAD_W-1:0]   s1_pad_r;
  logic [LEVEL_W-1:0] s1_level_r;
  logic [TIME_W-1:0]  s1_time_r;
  logic               s1_go;

  // Per-pad state
  logic [TIME_W-1:0]  last_hit_r [NUM_PADS];
  logic [LEVEL_W-1:0] peak_r     [NUM_PADS];
  logic [NUM_PADS-1:0] armed_r;

  // Output stage
  logic                out_valid_r;
  phmn_pkg::note_on_t  out_item_r;

  // Selected pad view
  logic [NUM_PADS-1:0] pad_sel;
  logic                pad_ok;
  logic [TIME_W-1:0]   last_sel;
  logic [LEVEL_W-1:0]  peak_sel;
  logic                armed_sel;
  logic [NOTE_W-1:0]   note_sel;
  logic [TIME_W-1:0]   elapsed;
  logic                qualify;
  logic                rising;
  logic                hit_end;
  logic [VEL_W-1:0]    vel;
  logic                emit;

  // Advance the input stage whenever the output register can take its result
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pad_r   <= in_tdata[1:0];
      s1_level_r <= in_tdata[13:2];
      s1_time_r  <= in_tdata[45:14];
    end
  end

  // Pick the addressed pad's state; an index past the last pad selects nothing
  always_comb begin
    pad_sel   = '0;
    last_sel  = '0;
    peak_sel  = '0;
    armed_sel = 1'b0;
    note_sel  = '0;
    for (int p = 0; p < NUM_PADS; p++) begin
      pad_sel[p] = (s1_pad_r == PAD_W'(p));
      if (pad_sel[p]) begin
        last_sel  = last_hit_r[p];
        peak_sel  = peak_r[p];
        armed_sel = armed_r[p];
        note_sel  = cfg.pad_note[p];
      end
    end
  end

  assign pad_ok  = |pad_sel;
  assign elapsed = s1_time_r - last_sel;
  assign qualify = pad_ok && (s1_level_r >= cfg.hit_threshold) &&
                   (elapsed >= {{(TIME_W-phmn_pkg::WINDOW_W){1'b0}},
                                cfg.retrigger_window_ms});
  assign rising  = peak_sel < s1_level_r;
  assign hit_end = qualify && armed_sel && !rising;
  assign vel     = peak_sel[LEVEL_W-1:phmn_pkg::VEL_SHIFT];
  assign emit    = hit_end && (vel != '0);

  // Update the addressed pad: arm, raise the peak, or close the hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
      for (int p = 0; p < NUM_PADS; p++) begin
        last_hit_r[p] <= '0;
        peak_r[p]     <= '0;
      end
    end else if (s1_go && qualify) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        if (pad_sel[p]) begin
          if (!armed_sel) begin
            armed_r[p] <= 1'b1;
            peak_r[p]  <= s1_level_r;
          end else if (rising) begin
            peak_r[p]  <= s1_level_r;
          end else begin
            armed_r[p]    <= 1'b0;
            peak_r[p]     <= '0;
            last_hit_r[p] <= s1_time_r;
          end
        end
      end
    end
  end

  // Hold the note-on until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_item_r.status_byte <= phmn_pkg::STATUS_NOTE_ON |
                                {{(phmn_pkg::STATUS_W-phmn_pkg::CHAN_W){1'b0}},
                                 cfg.note_channel};
      out_item_r.note_number <= note_sel;
      out_item_r.velocity    <= vel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_item_r};

endmodule

`default_nettype wire

### rtl/phmn_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module phmn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        cfg_pready
);

  // A stalled note-on keeps its valid and its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("note-on dropped or changed while stalled");

  // Every note-on is well formed: note-on status, nonzero velocity, zero pad bits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:4] == 4'h9) && (out_tdata[21:15] != 7'd0) &&
                   (out_tdata[23:22] == 2'b00))
    else $error("malformed note-on");

  // Input backpressure comes only from a stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // A fresh note-on follows a sample transaction through the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("note-on without a matching sample");

  // Register port never inserts wait states
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind piezo_hit_to_midi_note_on_core phmn_checker u_phmn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

`default_nettype wire
